[rtl/schit_pkg.sv]
// shared constants for the segment to circle hit test
`timescale 1ns / 1ps

package schit_pkg;

  // default coordinate width in bits, signed whole pixels
  localparam int DEF_COORD_BITS = 16;

  // register stages inside the split multiplier
  localparam int MUL_STAGES = 2;

endpackage : schit_pkg

[rtl/schit_if.sv]
// valid/ready channels: query items in, hit items out
`timescale 1ns / 1ps

interface schit_req_if #(
  parameter int COORD_BITS = schit_pkg::DEF_COORD_BITS
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] seg_start_x;
  logic signed [COORD_BITS-1:0] seg_start_y;
  logic signed [COORD_BITS-1:0] seg_end_x;
  logic signed [COORD_BITS-1:0] seg_end_y;
  logic signed [COORD_BITS-1:0] centre_x;
  logic signed [COORD_BITS-1:0] centre_y;
  logic        [COORD_BITS-2:0] radius;

  modport source (
    output valid, seg_start_x, seg_start_y, seg_end_x, seg_end_y,
           centre_x, centre_y, radius,
    input  ready
  );

  modport sink (
    input  valid, seg_start_x, seg_start_y, seg_end_x, seg_end_y,
           centre_x, centre_y, radius,
    output ready
  );
endinterface : schit_req_if

interface schit_rsp_if;
  logic valid;
  logic ready;
  logic hit;

  modport source (
    output valid, hit,
    input  ready
  );

  modport sink (
    input  valid, hit,
    output ready
  );
endinterface : schit_rsp_if

[rtl/segment_circle_hit_test.sv]
// top level: pipelined segment to circle hit test
//
// usage
//   req carries one query item: segment endpoints, circle centre (signed
//   pixels, COORD_BITS each) and radius (unsigned, COORD_BITS-1 bits).
//   rsp returns exactly one item per query, hit = 1 when the closest point
//   of the segment lies inside or on the circle. items leave in order.
//   rsp.valid rises when a query's item reaches stage 7, the last of seven
//   register stages; with rsp.ready high the result is then taken.
//   throughput is one item per cycle while rsp.ready is high: every stage
//   holds one item and passes it on whenever the stage after it moves.
//   each stage has its own valid bit and advances when it is empty or the
//   stage after it moves, so bubbles close up while rsp stalls and req
//   stays ready until every stage holds an item.
//   reset (rst, synchronous) clears all valid bits; no results are pending.
//   the interior case uses the identity |f|^2|d|^2 - (f.d)^2 = (f x d)^2,
//   compared against r^2|d|^2 through split multipliers.
//
// stage map
//   1 differences   2 products   3 sums   4 case flags and end tests
//   5-6 wide products   7 final select into the output register
`timescale 1ns / 1ps

module segment_circle_hit_test #(
  parameter int COORD_BITS = schit_pkg::DEF_COORD_BITS
) (
  input  logic        clk,
  input  logic        rst,
  schit_req_if.sink   req,
  schit_rsp_if.source rsp
);
  import schit_pkg::*;

  localparam int CW   = COORD_BITS;
  localparam int DW   = CW + 1;        // coordinate difference
  localparam int SQW  = 2 * CW;        // one square
  localparam int SUMW = 2 * CW + 1;    // sum of two squares, |cross|
  localparam int TW   = 2 * CW + 2;    // signed dot and cross products
  localparam int RW   = CW - 1;        // radius
  localparam int R2W  = 2 * RW;        // radius squared
  localparam int C2W  = 2 * SUMW;      // cross squared
  localparam int RDW  = R2W + SUMW;    // r^2 |d|^2
  localparam int NST  = 7;             // pipeline depth

  // valid bit per stage and per-stage advance
  logic [NST:1]   vld;
  logic [NST+1:1] en;

  always_comb begin
    en[NST+1] = rsp.ready;
    for (int k = NST; k >= 1; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[1]) begin
        vld[1] <= req.valid;
      end
      for (int k = 2; k <= NST; k++) begin
        if (en[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  assign req.ready = en[1];
  assign rsp.valid = vld[NST];

  // stage 1: d = p2 - p1, f = c - p1, g = c - p2
  logic signed [DW-1:0] dx, dy, fx, fy, gx, gy;
  logic        [RW-1:0] r1;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      dx <= DW'(req.seg_end_x) - DW'(req.seg_start_x);
      dy <= DW'(req.seg_end_y) - DW'(req.seg_start_y);
      fx <= DW'(req.centre_x)  - DW'(req.seg_start_x);
      fy <= DW'(req.centre_y)  - DW'(req.seg_start_y);
      gx <= DW'(req.centre_x)  - DW'(req.seg_end_x);
      gy <= DW'(req.centre_y)  - DW'(req.seg_end_y);
      r1 <= req.radius;
    end
  end

  // stage 2: narrow products
  logic signed [2*DW-1:0] m_dxdx, m_dydy, m_fxfx, m_fyfy, m_gxgx, m_gygy;
  logic signed [2*DW-1:0] m_fxdx, m_fydy, m_fxdy, m_fydx;
  logic        [R2W-1:0]  m_rr;

  assign m_dxdx = dx * dx;
  assign m_dydy = dy * dy;
  assign m_fxfx = fx * fx;
  assign m_fyfy = fy * fy;
  assign m_gxgx = gx * gx;
  assign m_gygy = gy * gy;
  assign m_fxdx = fx * dx;
  assign m_fydy = fy * dy;
  assign m_fxdy = fx * dy;
  assign m_fydx = fy * dx;
  assign m_rr   = r1 * r1;

  logic        [SQW-1:0]  sq_dx, sq_dy, sq_fx, sq_fy, sq_gx, sq_gy;
  logic signed [SUMW-1:0] p_fxdx, p_fydy, p_fxdy, p_fydx;
  logic        [R2W-1:0]  r2_s2;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      sq_dx  <= m_dxdx[SQW-1:0];
      sq_dy  <= m_dydy[SQW-1:0];
      sq_fx  <= m_fxfx[SQW-1:0];
      sq_fy  <= m_fyfy[SQW-1:0];
      sq_gx  <= m_gxgx[SQW-1:0];
      sq_gy  <= m_gygy[SQW-1:0];
      p_fxdx <= m_fxdx[SUMW-1:0];
      p_fydy <= m_fydy[SUMW-1:0];
      p_fxdy <= m_fxdy[SUMW-1:0];
      p_fydx <= m_fydx[SUMW-1:0];
      r2_s2  <= m_rr;
    end
  end

  // stage 3: |d|^2, |f|^2, |g|^2, dot and cross
  logic        [SUMW-1:0] dd3, ff3, gg3;
  logic signed [TW-1:0]   t3, c3;
  logic        [R2W-1:0]  r2_s3;

  always_ff @(posedge clk) begin
    if (en[3]) begin
      dd3   <= SUMW'(sq_dx) + SUMW'(sq_dy);
      ff3   <= SUMW'(sq_fx) + SUMW'(sq_fy);
      gg3   <= SUMW'(sq_gx) + SUMW'(sq_gy);
      t3    <= TW'(p_fxdx) + TW'(p_fydy);
      c3    <= TW'(p_fxdy) - TW'(p_fydx);
      r2_s3 <= r2_s2;
    end
  end

  // stage 4: pick the case; end cases are settled here
  logic                use_start, past_end;
  logic                hit_start, hit_end;
  logic signed [TW-1:0] c_neg;

  assign use_start = (dd3 == '0) || (t3 <= 0);
  assign past_end  = t3 >= $signed({1'b0, dd3});
  assign hit_start = ff3 <= SUMW'(r2_s3);
  assign hit_end   = gg3 <= SUMW'(r2_s3);
  assign c_neg     = -c3;

  logic            interior4, near4;
  logic [SUMW-1:0] cabs4, dd4;
  logic [R2W-1:0]  r2_s4;

  always_ff @(posedge clk) begin
    if (en[4]) begin
      interior4 <= !use_start && !past_end;
      near4     <= use_start ? hit_start : hit_end;
      cabs4     <= c3[TW-1] ? c_neg[SUMW-1:0] : c3[SUMW-1:0];
      dd4       <= dd3;
      r2_s4     <= r2_s3;
    end
  end

  // stages 5 and 6: cross^2 and r^2 |d|^2
  logic [C2W-1:0] c2_6;
  logic [RDW-1:0] rd_6;

  schit_mul #(.AW(SUMW), .BW(SUMW)) u_mul_cross (
    .clk (clk),
    .en  (en[6:5]),
    .a   (cabs4),
    .b   (cabs4),
    .p   (c2_6)
  );

  schit_mul #(.AW(R2W), .BW(SUMW)) u_mul_rad (
    .clk (clk),
    .en  (en[6:5]),
    .a   (r2_s4),
    .b   (dd4),
    .p   (rd_6)
  );

  logic interior5, near5, interior6, near6;

  always_ff @(posedge clk) begin
    if (en[5]) begin
      interior5 <= interior4;
      near5     <= near4;
    end
    if (en[6]) begin
      interior6 <= interior5;
      near6     <= near5;
    end
  end

  // stage 7: output register
  logic hit7;

  always_ff @(posedge clk) begin
    if (en[7]) begin
      hit7 <= interior6 ? (c2_6 <= C2W'(rd_6)) : near6;
    end
  end

  assign rsp.hit = hit7;

  // no result is offered right after reset
  ap_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !rsp.valid)
    else $error("result valid straight after reset");

  // an empty output stage means the whole pipe can take an item
  ap_empty_ready: assert property (@(posedge clk) disable iff (rst)
    !rsp.valid |-> req.ready)
    else $error("input stalled while output stage empty");

  // an item blocked ahead of the multipliers is kept
  ap_hold_mid: assert property (@(posedge clk) disable iff (rst)
    (vld[4] && !en[5]) |=> vld[4])
    else $error("item dropped at stage 4 during stall");

  // a stalled result is not overwritten by the stage behind it
  ap_hold_out: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && !rsp.ready) |=> (rsp.valid && $stable(hit7)))
    else $error("stalled result changed");

endmodule : segment_circle_hit_test

[rtl/schit_mul.sv]
// two stage unsigned multiplier built from four half-width partial products
`timescale 1ns / 1ps

module schit_mul #(
  parameter int AW = 33,
  parameter int BW = 33
) (
  input  logic                               clk,
  input  logic [schit_pkg::MUL_STAGES-1:0]   en,
  input  logic [AW-1:0]                      a,
  input  logic [BW-1:0]                      b,
  output logic [AW+BW-1:0]                   p
);
  import schit_pkg::*;

  localparam int ALO = (AW + 1) / 2;
  localparam int AHI = AW - ALO;
  localparam int BLO = (BW + 1) / 2;
  localparam int BHI = BW - BLO;
  localparam int PW  = AW + BW;

  logic [ALO+BLO-1:0] m_ll;
  logic [ALO+BHI-1:0] m_lh;
  logic [AHI+BLO-1:0] m_hl;
  logic [AHI+BHI-1:0] m_hh;

  logic [ALO+BLO-1:0] pll;
  logic [ALO+BHI-1:0] plh;
  logic [AHI+BLO-1:0] phl;
  logic [AHI+BHI-1:0] phh;
  logic [PW-1:0]      p_next;

  assign m_ll = a[ALO-1:0]  * b[BLO-1:0];
  assign m_lh = a[ALO-1:0]  * b[BW-1:BLO];
  assign m_hl = a[AW-1:ALO] * b[BLO-1:0];
  assign m_hh = a[AW-1:ALO] * b[BW-1:BLO];

  // partial products
  always_ff @(posedge clk) begin
    if (en[0]) begin
      pll <= m_ll;
      plh <= m_lh;
      phl <= m_hl;
      phh <= m_hh;
    end
  end

  // recombine with shifts
  always_comb begin
    p_next = PW'(pll)
           + (PW'(plh) << BLO)
           + (PW'(phl) << ALO)
           + (PW'(phh) << (ALO + BLO));
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      p <= p_next;
    end
  end

endmodule : schit_mul
